// ----- src/bfr_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte stuffing framer package
// Shared types and constants for the framer's front end, queue and back end.
// ---------------------------------------------------------------------------
package bfr_pkg;

	localparam int BYTE_BITS = 8;
	localparam int BIT_IDX_W = $clog2(BYTE_BITS);

	typedef logic [BYTE_BITS-1:0] byte_t;

	localparam byte_t FLAG_RESET   = 8'h0F;
	localparam byte_t ESCAPE_RESET = 8'hF0;

	// Configuration register indexes
	localparam int REG_IDX_W = 2;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_UNSTUFF_MODE = 2'd0,
		REG_FLAG_BYTE    = 2'd1,
		REG_ESCAPE_BYTE  = 2'd2
	} reg_idx_t;

	// Byte slots of one job, in send order
	localparam int SLOT_OPEN  = 0;
	localparam int SLOT_ESC   = 1;
	localparam int SLOT_DATA  = 2;
	localparam int SLOT_CLOSE = 3;
	localparam int SLOTS      = 4;

	typedef struct packed {
		logic  unstuff_mode;
		byte_t flag_byte;
		byte_t escape_byte;
	} cfg_t;

	// One queued job: which bytes to send, and whether it ends a frame.
	// No bytes with ends set means a bare end marker.
	typedef struct packed {
		logic  open_flag;
		logic  escape;
		logic  data;
		logic  close_flag;
		logic  ends;
		byte_t data_byte;
	} job_t;

endpackage

// ----- src/bfr_ifs.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte stuffing framer channels
// Valid/ready channels for incoming bits and outgoing result bits.
// ---------------------------------------------------------------------------
interface bfr_bits_if;
	logic valid;
	logic ready;
	logic in_bit;
	logic starts_frame;
	logic ends_frame;

	modport source(output valid, output in_bit, output starts_frame, output ends_frame,
		input ready);
	modport sink(input valid, input in_bit, input starts_frame, input ends_frame,
		output ready);
endinterface

interface bfr_result_if;
	logic valid;
	logic ready;
	logic out_bit;
	logic out_bit_valid;
	logic ends_output_frame;

	modport source(output valid, output out_bit, output out_bit_valid,
		output ends_output_frame, input ready);
	modport sink(input valid, input out_bit, input out_bit_valid,
		input ends_output_frame, output ready);
endinterface

// ----- src/bfr_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte stuffing framer front end
// Gathers bits into bytes, classifies them and queues send jobs.
// ---------------------------------------------------------------------------
module bfr_front (
	input  logic          clk,
	input  logic          arst_n,
	bfr_bits_if.sink      bits,
	input  bfr_pkg::cfg_t cfg,
	output bfr_pkg::job_t job,
	output logic          job_push,
	input  logic          job_full
);

	bfr_pkg::byte_t               gather_q;
	logic [bfr_pkg::BIT_IDX_W-1:0] count_q;
	logic                         skip_q;

	bfr_pkg::byte_t               gather_eff;
	bfr_pkg::byte_t               gather_new;
	logic [bfr_pkg::BIT_IDX_W-1:0] count_eff;
	logic                         skip_eff;
	logic                         skip_new;
	logic                         complete;
	logic                         special;
	logic                         drop;
	logic                         accept;

	assign bits.ready = !job_full;
	assign accept     = bits.valid && bits.ready;

	always_comb begin
		gather_eff = bits.starts_frame ? '0 : gather_q;
		count_eff  = bits.starts_frame ? '0 : count_q;
		skip_eff   = bits.starts_frame ? 1'b0 : skip_q;
		gather_new = {gather_eff[bfr_pkg::BYTE_BITS-2:0], bits.in_bit};
		complete   = (count_eff == bfr_pkg::BIT_IDX_W'(bfr_pkg::BYTE_BITS - 1));
		special    = (gather_new == cfg.flag_byte) || (gather_new == cfg.escape_byte);
		drop       = cfg.unstuff_mode && complete && special && !skip_eff;
		// stuff mode never sets skip; unstuff sets it on a dropped byte
		skip_new   = complete ? drop : skip_eff;

		job.open_flag  = !cfg.unstuff_mode && bits.starts_frame;
		job.escape     = !cfg.unstuff_mode && complete && special;
		job.data       = complete && !drop;
		job.close_flag = !cfg.unstuff_mode && bits.ends_frame;
		job.ends       = bits.ends_frame;
		job.data_byte  = gather_new;

		job_push = accept && (job.open_flag || job.escape || job.data || job.ends);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_q <= '0;
			count_q  <= '0;
			skip_q   <= 1'b0;
		end else if (accept) begin
			if (bits.ends_frame) begin
				gather_q <= '0;
				count_q  <= '0;
				skip_q   <= 1'b0;
			end else begin
				gather_q <= complete ? '0 : gather_new;
				count_q  <= count_eff + 1'b1;
				skip_q   <= skip_new;
			end
		end
	end

endmodule

// ----- src/bfr_fifo.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte stuffing framer job queue
// Small register queue between the front and back ends.
// ---------------------------------------------------------------------------
module bfr_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bfr_pkg::job_t push_job,
	input  logic          pop,
	output bfr_pkg::job_t head,
	output logic          not_empty,
	output logic          full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bfr_pkg::job_t     entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign head      = entries_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CNT_W'(DEPTH)))
		else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("job queue underflow");

endmodule

// ----- src/bfr_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte stuffing framer back end
// Serializes queued jobs MSB first into a registered result channel.
// ---------------------------------------------------------------------------
module bfr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  bfr_pkg::cfg_t cfg,
	input  bfr_pkg::job_t head,
	input  logic          head_valid,
	output logic          pop,
	bfr_result_if.source  res
);

	logic                          cur_valid_q;
	logic [bfr_pkg::SLOTS-1:0]     mask_q;
	logic                          ends_q;
	bfr_pkg::byte_t                data_byte_q;
	logic [bfr_pkg::BIT_IDX_W-1:0] bit_idx_q;

	logic                          res_valid_q;
	logic                          res_bit_q;
	logic                          res_bit_valid_q;
	logic                          res_ends_q;

	bfr_pkg::byte_t                sel_byte;
	logic [bfr_pkg::SLOTS-1:0]     low_slot;
	logic [bfr_pkg::SLOTS-1:0]     mask_next;
	logic                          bare;
	logic                          last_bit;
	logic                          cur_done;
	logic                          emit;

	always_comb begin
		priority if (mask_q[bfr_pkg::SLOT_OPEN]) begin
			sel_byte = cfg.flag_byte;
		end else if (mask_q[bfr_pkg::SLOT_ESC]) begin
			sel_byte = cfg.escape_byte;
		end else if (mask_q[bfr_pkg::SLOT_DATA]) begin
			sel_byte = data_byte_q;
		end else begin
			sel_byte = cfg.flag_byte;
		end
		low_slot  = mask_q & (~mask_q + 1'b1);
		bare      = (mask_q == '0);
		last_bit  = bare ||
			(bit_idx_q == bfr_pkg::BIT_IDX_W'(bfr_pkg::BYTE_BITS - 1));
		mask_next = last_bit ? (mask_q & ~low_slot) : mask_q;
		cur_done  = last_bit && (mask_next == '0);
		emit      = cur_valid_q && (!res_valid_q || res.ready);
		pop       = head_valid && (!cur_valid_q || (emit && cur_done));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			mask_q      <= '0;
			bit_idx_q   <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			mask_q      <= {head.close_flag, head.data, head.escape, head.open_flag};
			bit_idx_q   <= '0;
		end else if (emit) begin
			cur_valid_q <= !cur_done;
			mask_q      <= mask_next;
			bit_idx_q   <= last_bit ? '0 : bit_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ends_q      <= head.ends;
			data_byte_q <= head.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_bit_q       <= !bare &&
				sel_byte[bfr_pkg::BIT_IDX_W'(bfr_pkg::BYTE_BITS - 1) - bit_idx_q];
			res_bit_valid_q <= !bare;
			res_ends_q      <= ends_q && cur_done;
		end
	end

	assign res.valid             = res_valid_q;
	assign res.out_bit           = res_bit_q;
	assign res.out_bit_valid     = res_bit_valid_q;
	assign res.ends_output_frame = res_ends_q;

	a_bare_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && bare) |-> (ends_q && cur_done))
		else $error("bare marker job without frame end");

endmodule

// ----- src/byte_stuffing_framer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte stuffing framer
// Bit-serial flag/escape framer (stuff) and deframer (unstuff) top level.
// ---------------------------------------------------------------------------
// The first result of an item shows on the result channel once the item has
//   passed the queue write, the back end load and the result register.
// Throughput: one input item per cycle while the job queue has room; the back
//   end sends one result bit per cycle while the result channel is ready, so an
//   escaped byte (16 result bits per 8 input items) lets the queue fill up.
// Reset: arst_n clears gathering state, queue pointers and result valid, and
//   loads the register defaults (stuff mode, flag 0x0F, escape 0xF0).
// ---------------------------------------------------------------------------
module byte_stuffing_framer #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bfr_bits_if.sink                      bits_ch,
	bfr_result_if.source                  result_ch,
	input  logic                          wr_en,
	input  logic [bfr_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [bfr_pkg::BYTE_BITS-1:0] wr_data
);

	// Configuration registers; the user writes them only while the datapath is idle, the block does not enforce it
	bfr_pkg::cfg_t cfg_q;

	// Front end to queue
	bfr_pkg::job_t push_job;
	logic          fifo_push;
	logic          fifo_full;

	// Queue to back end
	bfr_pkg::job_t head_job;
	logic          head_valid;
	logic          fifo_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unstuff_mode <= 1'b0;
			cfg_q.flag_byte    <= bfr_pkg::FLAG_RESET;
			cfg_q.escape_byte  <= bfr_pkg::ESCAPE_RESET;
		end else if (wr_en) begin
			// writes to an index past the list are dropped
			unique case (wr_index)
				bfr_pkg::REG_UNSTUFF_MODE: cfg_q.unstuff_mode <= wr_data[0];
				bfr_pkg::REG_FLAG_BYTE:    cfg_q.flag_byte    <= wr_data;
				bfr_pkg::REG_ESCAPE_BYTE:  cfg_q.escape_byte  <= wr_data;
				default:                   cfg_q              <= cfg_q;
			endcase
		end
	end

	// Front end: gathers each byte and decides which bytes the item sends
	// (opening flag, escape, data, closing flag) or whether it only marks
	// the frame end. Items that send nothing are not queued.
	bfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.bits     (bits_ch),
		.cfg      (cfg_q),
		.job      (push_job),
		.job_push (fifo_push),
		.job_full (fifo_full)
	);

	// Short queue so the bit gatherer keeps taking items while the
	// serializer is busy with a two-byte escape sequence.
	bfr_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_job  (push_job),
		.pop       (fifo_pop),
		.head      (head_job),
		.not_empty (head_valid),
		.full      (fifo_full)
	);

	// Back end: walks the job's bytes MSB first into the result register;
	// the next job loads on the cycle the current one sends its last bit.
	bfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head_job),
		.head_valid (head_valid),
		.pop        (fifo_pop),
		.res        (result_ch)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> !fifo_full)
		else $error("front end pushed into a full queue");

	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && !result_ch.out_bit_valid) |->
		(result_ch.ends_output_frame && !result_ch.out_bit))
		else $error("bare marker result malformed");

	a_stuff_no_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && !cfg_q.unstuff_mode) |-> result_ch.out_bit_valid)
		else $error("bare marker in stuff mode");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte stuffing framer testbench
// Sends bit items in stuff and unstuff modes under several flag and escape
// settings. A built-in framing predictor works out the expected result bits,
// and each result bit is checked against them in order, with random idle
// cycles on both channels.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int SETTLE_CYCLES = 12;    // well past the item latency
	localparam int QUIET_LIMIT   = 1000;  // cycles with no item moving on either side
	localparam int PHASE_ITEMS   = 2;     // least random items per configuration phase

	typedef struct packed {
		logic in_bit;
		logic starts_frame;
		logic ends_frame;
	} bit_item_t;

	typedef struct packed {
		logic out_bit;
		logic out_bit_valid;
		logic ends_output_frame;
	} result_bit_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [bfr_pkg::REG_IDX_W-1:0] wr_index;
	logic [bfr_pkg::BYTE_BITS-1:0] wr_data;

	bfr_bits_if   bits_ch();
	bfr_result_if result_ch();

	byte_stuffing_framer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.bits_ch  (bits_ch),
		.result_ch(result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Bits waiting to be sent, and result bits still owed by the block
	bit_item_t   bit_feed[$];
	result_bit_t owed_bits[$];

	int fail_count = 0;

	// Register copies, as the block holds them
	logic           mode_unstuff = 1'b0;
	bfr_pkg::byte_t flag_val     = bfr_pkg::FLAG_RESET;
	bfr_pkg::byte_t escape_val   = bfr_pkg::ESCAPE_RESET;

	// Byte assembly state of the predictor
	bfr_pkg::byte_t acc_byte     = '0;
	int             acc_count    = 0;
	logic           last_dropped = 1'b0;

	// Idle control: calm stretches turn off waits for 16 items at a time
	int tx_gap   = 0;
	int tx_count = 0;
	bit tx_calm  = 1'b0;
	int rx_hold  = 0;
	int rx_count = 0;
	bit rx_calm  = 1'b0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Framing predictor
	// -----------------------------------------------------------------------

	// One output byte goes out MSB first, one result bit each
	function automatic void owe_byte(bfr_pkg::byte_t b);
		result_bit_t r;
		for (int i = bfr_pkg::BYTE_BITS - 1; i >= 0; i--) begin
			r.out_bit = b[i];
			r.out_bit_valid = 1'b1;
			r.ends_output_frame = 1'b0;
			owed_bits.insert(owed_bits.size(), r);
		end
	endfunction

	function automatic void frame_step(logic din, logic sof, logic eof);
		int             made_from;
		bfr_pkg::byte_t done_byte;
		logic           hit;
		result_bit_t    marker;
		made_from = owed_bits.size();
		if (sof) begin
			acc_byte = '0;
			acc_count = 0;
			last_dropped = 1'b0;
			if (!mode_unstuff)
				owe_byte(flag_val);
		end
		acc_byte = {acc_byte[bfr_pkg::BYTE_BITS-2:0], din};
		acc_count++;
		if (acc_count == bfr_pkg::BYTE_BITS) begin
			done_byte = acc_byte;
			// flag equal to escape still counts as one match
			hit = (done_byte == flag_val) || (done_byte == escape_val);
			if (!mode_unstuff) begin
				if (hit)
					owe_byte(escape_val);
				owe_byte(done_byte);
				last_dropped = 1'b0;
			end else if (hit && !last_dropped) begin
				// first special byte of a pair is the escape itself: dropped
				last_dropped = 1'b1;
			end else begin
				owe_byte(done_byte);
				last_dropped = 1'b0;
			end
			acc_byte = '0;
			acc_count = 0;
		end
		if (eof) begin
			if (!mode_unstuff) begin
				owe_byte(flag_val);
				owed_bits[owed_bits.size()-1].ends_output_frame = 1'b1;
			end else if (owed_bits.size() > made_from) begin
				owed_bits[owed_bits.size()-1].ends_output_frame = 1'b1;
			end else begin
				// nothing came out of this bit: a bare end marker
				marker.out_bit = 1'b0;
				marker.out_bit_valid = 1'b0;
				marker.ends_output_frame = 1'b1;
				owed_bits.insert(owed_bits.size(), marker);
			end
			// a trailing partial byte is thrown away
			acc_byte = '0;
			acc_count = 0;
			last_dropped = 1'b0;
		end
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus builders
	// -----------------------------------------------------------------------

	// Queues the top len bits of pat, MSB first; sof on the first, eof on the last
	function automatic int queue_pattern(logic [15:0] pat, int len, logic sof, logic eof);
		bit_item_t it;
		for (int k = 0; k < len; k++) begin
			it.in_bit = pat[15-k];
			it.starts_frame = sof && (k == 0);
			it.ends_frame = eof && (k == len - 1);
			bit_feed.insert(bit_feed.size(), it);
		end
		return len;
	endfunction

	// Data bytes lean on the flag, the escape and both extremes
	function automatic bfr_pkg::byte_t pick_byte();
		case ($urandom_range(0, 6))
			0: return flag_val;
			1: return escape_val;
			2: return 8'h00;
			3: return 8'hFF;
			default: return bfr_pkg::byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	// Well-formed frame: 0..3 whole bytes, sometimes a partial tail byte
	function automatic int queue_frame();
		int n_bytes;
		int tail;
		int sent;
		n_bytes = $urandom_range(0, 3);
		tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
		if (n_bytes == 0 && tail == 0)
			tail = $urandom_range(1, 7);
		sent = 0;
		for (int k = 0; k < n_bytes; k++)
			sent += queue_pattern({pick_byte(), 8'h00}, bfr_pkg::BYTE_BITS, k == 0,
				(k == n_bytes - 1) && (tail == 0));
		if (tail != 0)
			sent += queue_pattern({pick_byte(), 8'h00}, tail, n_bytes == 0, 1'b1);
		return sent;
	endfunction

	// Noise: random bits with stray frame starts and ends
	function automatic int queue_noise();
		int len;
		bit_item_t it;
		len = $urandom_range(1, 12);
		for (int k = 0; k < len; k++) begin
			it.in_bit = $urandom_range(0, 1);
			it.starts_frame = ($urandom_range(0, 5) == 0);
			it.ends_frame = ($urandom_range(0, 5) == 0);
			bit_feed.insert(bit_feed.size(), it);
		end
		return len;
	endfunction

	// -----------------------------------------------------------------------
	// Register writes and idle waits (initial block only)
	// -----------------------------------------------------------------------

	task automatic write_reg(bfr_pkg::reg_idx_t idx, bfr_pkg::byte_t val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			bfr_pkg::REG_UNSTUFF_MODE: mode_unstuff = val[0];
			bfr_pkg::REG_FLAG_BYTE:    flag_val = val;
			bfr_pkg::REG_ESCAPE_BYTE:  escape_val = val;
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic apply_settings(logic unstuff, bfr_pkg::byte_t flag, bfr_pkg::byte_t esc);
		write_reg(bfr_pkg::REG_UNSTUFF_MODE, {7'd0, unstuff});
		write_reg(bfr_pkg::REG_FLAG_BYTE, flag);
		write_reg(bfr_pkg::REG_ESCAPE_BYTE, esc);
	endtask

	// Sender holds off until every owed result bit is back, then lets
	// bits that produce nothing finish inside the block
	task automatic drain_and_settle();
		while (bit_feed.size() != 0 || bits_ch.valid || owed_bits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// -----------------------------------------------------------------------
	// Bit driver: one item per handshake, random gap after each
	// -----------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : bit_driver
		bit_item_t nxt_item;
		if (!arst_n) begin
			bits_ch.valid <= 1'b0;
			bits_ch.in_bit <= 1'b0;
			bits_ch.starts_frame <= 1'b0;
			bits_ch.ends_frame <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (bits_ch.valid && bits_ch.ready)
				frame_step(bits_ch.in_bit, bits_ch.starts_frame, bits_ch.ends_frame);
			if (!bits_ch.valid || bits_ch.ready) begin
				if (tx_gap != 0) begin
					bits_ch.valid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (bit_feed.size() != 0) begin
					nxt_item = bit_feed.pop_front();
					bits_ch.valid <= 1'b1;
					bits_ch.in_bit <= nxt_item.in_bit;
					bits_ch.starts_frame <= nxt_item.starts_frame;
					bits_ch.ends_frame <= nxt_item.ends_frame;
					if (tx_count % 16 == 0)
						tx_calm = ($urandom_range(0, 2) == 0);
					tx_gap <= tx_calm ? 0 : $urandom_range(0, 7);
					tx_count++;
				end else begin
					bits_ch.valid <= 1'b0;
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Result monitor: checks each bit against the oldest owed one, then
	// stalls ready for a random number of cycles
	// -----------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : result_monitor
		int hold;
		result_bit_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_hold <= 0;
		end else begin
			hold = rx_hold;
			if (result_ch.valid && result_ch.ready) begin
				if (owed_bits.size() == 0) begin
					$error("unexpected result: out_bit %0b out_bit_valid %0b ends_output_frame %0b",
						result_ch.out_bit, result_ch.out_bit_valid, result_ch.ends_output_frame);
					fail_count++;
				end else begin
					want = owed_bits.pop_front();
					if (result_ch.out_bit !== want.out_bit) begin
						$error("out_bit: expected %0b, got %0b", want.out_bit, result_ch.out_bit);
						fail_count++;
					end
					if (result_ch.out_bit_valid !== want.out_bit_valid) begin
						$error("out_bit_valid: expected %0b, got %0b",
							want.out_bit_valid, result_ch.out_bit_valid);
						fail_count++;
					end
					if (result_ch.ends_output_frame !== want.ends_output_frame) begin
						$error("ends_output_frame: expected %0b, got %0b",
							want.ends_output_frame, result_ch.ends_output_frame);
						fail_count++;
					end
				end
				if (rx_count % 16 == 0)
					rx_calm = ($urandom_range(0, 2) == 0);
				hold = rx_calm ? 0 : $urandom_range(0, 7);
				rx_count++;
			end
			if (hold > 0) begin
				result_ch.ready <= 1'b0;
				rx_hold <= hold - 1;
			end else begin
				result_ch.ready <= 1'b1;
				rx_hold <= 0;
			end
		end
	end

	// Watchdog: a hang shows up as a long run of cycles with nothing moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((bits_ch.valid && bits_ch.ready) || (result_ch.valid && result_ch.ready) || wr_en)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("byte_stuffing_framer verification failed");
				$finish;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Test sequence
	// -----------------------------------------------------------------------
	initial begin
		int made;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		bits_ch.valid = 1'b0;
		bits_ch.in_bit = 1'b0;
		bits_ch.starts_frame = 1'b0;
		bits_ch.ends_frame = 1'b0;
		result_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, stuff mode on reset defaults:
		//   start and end on the same bit -> opening then closing flag
		//   a flag-valued byte with no frame start -> escape, byte, closing flag
		made = queue_pattern(16'h8000, 1, 1'b1, 1'b1);
		made = queue_pattern({bfr_pkg::FLAG_RESET, 8'h00}, bfr_pkg::BYTE_BITS, 1'b0, 1'b1);
		drain_and_settle();

		// Directed, unstuff mode:
		//   a one-bit frame gives only a bare end marker
		//   escape, escape: the first is dropped, the second passes and ends the frame
		write_reg(bfr_pkg::REG_UNSTUFF_MODE, 8'h01);
		made = queue_pattern(16'h0000, 1, 1'b1, 1'b1);
		made = queue_pattern({bfr_pkg::ESCAPE_RESET, bfr_pkg::ESCAPE_RESET},
			2 * bfr_pkg::BYTE_BITS, 1'b1, 1'b1);
		drain_and_settle();

		// Random phases, each on its own setting. Noise may leave a byte half
		// gathered across a phase boundary, which covers a mode change mid-frame.
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: apply_settings(1'b0, 8'h7E, 8'h7D);
				1: apply_settings(1'b1, 8'h7E, 8'h7D);
				2: apply_settings(1'b1, 8'h00, 8'h00);   // flag equals escape, low end
				3: apply_settings(1'b0, 8'hFF, 8'hFF);   // flag equals escape, high end
				4: apply_settings(1'b1, 8'hFF, 8'h00);
				5: apply_settings(1'b0, 8'h00, 8'hFF);
				default: apply_settings(1'($urandom_range(0, 1)),
					bfr_pkg::byte_t'($urandom_range(0, 255)),
					bfr_pkg::byte_t'($urandom_range(0, 255)));
			endcase
			made = 0;
			while (made < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0)
					made += queue_noise();
				else
					made += queue_frame();
			end
			drain_and_settle();
		end

		if (owed_bits.size() != 0) begin
			$error("%0d result bits never arrived", owed_bits.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("byte_stuffing_framer verification clean");
		else
			$display("byte_stuffing_framer verification failed");
		$finish;
	end

endmodule
